>>> src/buffer_pool_lru_frame_manager_macros.svh
// Assertion macros for the buffer pool frame manager.
`ifndef BUFFER_POOL_LRU_FRAME_MANAGER_MACROS_SVH
`define BUFFER_POOL_LRU_FRAME_MANAGER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bplru_pkg.sv
// Shared types and codes of the buffer pool frame manager.
`timescale 1ns / 1ps
package bplru_pkg;

  localparam int unsigned PageW   = 31;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned FrameW  = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned FillW   = 2;
  localparam int unsigned MaxResults = 16;

  localparam logic [CmdW-1:0] CmdPin      = 3'd0;
  localparam logic [CmdW-1:0] CmdUnpin    = 3'd1;
  localparam logic [CmdW-1:0] CmdNewPage  = 3'd2;
  localparam logic [CmdW-1:0] CmdDelete   = 3'd3;
  localparam logic [CmdW-1:0] CmdFlush    = 3'd4;
  localparam logic [CmdW-1:0] CmdFlushAll = 3'd5;

  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StAllPinned = 3'd1;
  localparam logic [StatusW-1:0] StNotRes    = 3'd2;
  localparam logic [StatusW-1:0] StPinZero   = 3'd3;
  localparam logic [StatusW-1:0] StPinOvf    = 3'd4;

  localparam logic [FillW-1:0] FillNone = 2'd0;
  localparam logic [FillW-1:0] FillRead = 2'd1;
  localparam logic [FillW-1:0] FillZero = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [PageW-1:0]   page_id;
    logic               mark_dirty;
  } req_t;

  typedef struct packed {
    logic [FrameW-1:0]  frame;
    logic [StatusW-1:0] status;
    logic               hit;
    logic [FillW-1:0]   fill;
    logic               writeback_valid;
    logic [PageW-1:0]   writeback_page;
    logic [FrameW-1:0]  writeback_frame;
    logic               last;
  } rsp_t;

  // Per-frame update commands broadcast to the frame cells.
  typedef struct packed {
    logic load;        // install page_id, set valid, pins = 1
    logic set_dirty;
    logic clr_dirty;
    logic inc_pin;
    logic dec_pin;
    logic free;        // clear valid, dirty, pins
  } cell_op_t;

endpackage

>>> src/bplru_if.sv
// Valid/ready channel interface carrying one item.
`timescale 1ns / 1ps
interface bplru_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/bplru_frame_cell.sv
// One frame cell: page tag, flags, pin count and one slot of the LRU chain.
`timescale 1ns / 1ps
module bplru_frame_cell #(
  parameter int unsigned PinBits = 8,
  parameter int unsigned IdxW    = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [IdxW-1:0]          reset_slot_i,
  input  logic [bplru_pkg::PageW-1:0] page_i,
  input  bplru_pkg::cell_op_t      op_i,
  output logic                     match_o,
  output logic                     valid_o,
  output logic                     dirty_o,
  output logic [PinBits-1:0]       pins_o,
  output logic [bplru_pkg::PageW-1:0] page_o,
  output logic                     in_lru_o,
  // LRU slot: holds a frame number; shifts toward the LRU end on a move.
  input  logic                     slot_shift_i,
  input  logic                     slot_load_i,
  input  logic [IdxW-1:0]          slot_next_i,
  input  logic [IdxW-1:0]          slot_mru_i,
  input  logic                     lru_set_i,
  input  logic                     lru_clr_i,
  output logic [IdxW-1:0]          slot_o
);
  import bplru_pkg::*;

  logic [PageW-1:0]   page_q;
  logic               valid_q, dirty_q, in_lru_q;
  logic [PinBits-1:0] pins_q;
  logic [IdxW-1:0]    slot_q;

  always_ff @(posedge clk_i) begin
    if (op_i.load) page_q <= page_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      dirty_q  <= 1'b0;
      pins_q   <= '0;
      in_lru_q <= 1'b1;
      slot_q   <= reset_slot_i;
    end else begin
      if (op_i.free) begin
        valid_q <= 1'b0;
        dirty_q <= 1'b0;
        pins_q  <= '0;
      end else begin
        if (op_i.load) begin
          valid_q <= 1'b1;
          pins_q  <= {{(PinBits-1){1'b0}}, 1'b1};
        end else if (op_i.inc_pin) begin
          pins_q <= pins_q + 1'b1;
        end else if (op_i.dec_pin) begin
          pins_q <= pins_q - 1'b1;
        end
        if (op_i.set_dirty) dirty_q <= 1'b1;
        else if (op_i.clr_dirty) dirty_q <= 1'b0;
      end
      if (lru_set_i) in_lru_q <= 1'b1;
      else if (lru_clr_i) in_lru_q <= 1'b0;
      if (slot_load_i) slot_q <= slot_mru_i;
      else if (slot_shift_i) slot_q <= slot_next_i;
    end
  end

  assign match_o  = valid_q && (page_q == page_i);
  assign valid_o  = valid_q;
  assign dirty_o  = dirty_q;
  assign pins_o   = pins_q;
  assign page_o   = page_q;
  assign in_lru_o = in_lru_q;
  assign slot_o   = slot_q;
endmodule

>>> src/buffer_pool_lru_frame_manager.sv
// Top level of the LRU buffer pool frame manager.
// The request channel (req) carries command, page_id and mark_dirty; the response
// channel (rsp) carries one result item per beat, with last set on the final one.
// Each command is accepted in the idle state, looked up against all frame cells in
// the next cycle (tag compare and victim choice are broadcast across the cells),
// and its result item sits in an output register until taken. A single-result
// command thus passes through the execute state and the output register, and the
// next item is taken the cycle after the result is taken. Flush all walks the
// frames one per cycle, but pauses while each result item is held for output.
// The LRU order lives in a chain of slots, one per cell; moving a frame to the
// MRU end shifts the slots above it down by one, all together.
// Victim choice scans slots from the LRU end through a priority pick.
// Reset empties every frame, clears pins and dirty marks and sets the LRU order to
// frame 0 least recent. While the receiver stalls, the result holds and no new
// item is accepted.
`timescale 1ns / 1ps
`include "buffer_pool_lru_frame_manager_macros.svh"
module buffer_pool_lru_frame_manager #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned PIN_BITS   = 8
) (
  input logic clk_i,
  input logic rst_ni,
  bplru_if.sink   req,
  bplru_if.source rsp
);
  import bplru_pkg::*;

  localparam int unsigned IdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [4:0]      nres_q, nres_d;
  logic            any_q, any_d;

  cell_op_t          op [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] match, valid, dirty, in_lru, lru_set, lru_clr;
  logic [NUM_FRAMES-1:0] slot_shift, slot_load;
  logic [PIN_BITS-1:0] pins [NUM_FRAMES];
  logic [PageW-1:0]    pages [NUM_FRAMES];
  logic [IdxW-1:0]     slot [NUM_FRAMES];
  logic [IdxW-1:0]     mv_frame;
  logic                mv_en;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    bplru_frame_cell #(.PinBits(PIN_BITS), .IdxW(IdxW)) u_cell (
      .clk_i, .rst_ni,
      .reset_slot_i (IdxW'(i)),
      .page_i       (req_q.page_id),
      .op_i         (op[i]),
      .match_o      (match[i]),
      .valid_o      (valid[i]),
      .dirty_o      (dirty[i]),
      .pins_o       (pins[i]),
      .page_o       (pages[i]),
      .in_lru_o     (in_lru[i]),
      .slot_shift_i (slot_shift[i]),
      .slot_load_i  (slot_load[i]),
      .slot_next_i  (slot[(i + 1) % NUM_FRAMES]),
      .slot_mru_i   (mv_frame),
      .lru_set_i    (lru_set[i]),
      .lru_clr_i    (lru_clr[i]),
      .slot_o       (slot[i])
    );
  end

  // Lookup hit and victim choice.
  logic            hit_f;
  logic [IdxW-1:0] hit_idx;
  logic            vic_f;
  logic [IdxW-1:0] vic_idx;
  logic [NUM_FRAMES-1:0] at_or_above;

  always_comb begin
    hit_f = 1'b0;
    hit_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_f = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
    vic_f = 1'b0;
    vic_idx = '0;
    for (int p = NUM_FRAMES - 1; p >= 0; p--) begin
      if (in_lru[slot[p]] && pins[slot[p]] == '0) begin
        vic_f = 1'b1;
        vic_idx = slot[p];
      end
    end
  end

  // Slot shift for a move to MRU: slots at and above the frame's position shift down; the MRU slot loads the frame.
  always_comb begin
    at_or_above = '0;
    for (int p = 0; p < NUM_FRAMES; p++) begin
      if (p == 0) at_or_above[p] = (slot[p] == mv_frame);
      else at_or_above[p] = at_or_above[p-1] || (slot[p] == mv_frame);
    end
    for (int p = 0; p < NUM_FRAMES; p++) begin
      slot_shift[p] = mv_en && at_or_above[p] && (p != NUM_FRAMES - 1);
      slot_load[p]  = mv_en && at_or_above[p] && (p == NUM_FRAMES - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.payload;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
      nres_q  <= '0;
      any_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      nres_q  <= nres_d;
      any_q   <= any_d;
    end
  end

  logic [PIN_BITS-1:0] pin_max;
  logic [PIN_BITS-1:0] hpins;
  assign pin_max = '1;
  assign hpins = pins[hit_idx];

  always_comb begin
    state_d = state_q;
    rsp_d   = rsp_q;
    scan_d  = scan_q;
    nres_d  = nres_q;
    any_d   = any_q;
    mv_en   = 1'b0;
    mv_frame = hit_idx;
    lru_set = '0;
    lru_clr = '0;
    for (int i = 0; i < NUM_FRAMES; i++) op[i] = '0;
    req.ready = (state_q == ST_IDLE);
    rsp.valid = (state_q == ST_OUT);
    rsp.payload = rsp_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req.valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        rsp_d = '0;
        rsp_d.last = 1'b1;
        state_d = ST_OUT;
        case (req_q.command)
          CmdPin, CmdNewPage: begin
            if (hit_f && req_q.command == CmdPin) begin
              rsp_d.frame = FrameW'(hit_idx);
              rsp_d.hit = 1'b1;
              if (hpins == pin_max) begin
                rsp_d.status = StPinOvf;
              end else begin
                op[hit_idx].inc_pin = 1'b1;
                lru_clr[hit_idx] = 1'b1;
              end
            end else if (hit_f) begin
              rsp_d.frame = FrameW'(hit_idx);
              rsp_d.hit = 1'b1;
              rsp_d.fill = FillZero;
              op[hit_idx].load = 1'b1;
              op[hit_idx].set_dirty = 1'b1;
              lru_clr[hit_idx] = 1'b1;
            end else if (!vic_f) begin
              rsp_d.status = StAllPinned;
            end else begin
              rsp_d.frame = FrameW'(vic_idx);
              rsp_d.fill = (req_q.command == CmdNewPage) ? FillZero : FillRead;
              if (valid[vic_idx] && dirty[vic_idx]) begin
                rsp_d.writeback_valid = 1'b1;
                rsp_d.writeback_page = pages[vic_idx];
                rsp_d.writeback_frame = FrameW'(vic_idx);
              end
              op[vic_idx].load = 1'b1;
              if (req_q.command == CmdNewPage) op[vic_idx].set_dirty = 1'b1;
              else op[vic_idx].clr_dirty = 1'b1;
              lru_clr[vic_idx] = 1'b1;
            end
          end
          CmdUnpin: begin
            if (!hit_f) begin
              rsp_d.status = StNotRes;
            end else begin
              rsp_d.frame = FrameW'(hit_idx);
              rsp_d.hit = 1'b1;
              if (hpins == '0) begin
                rsp_d.status = StPinZero;
              end else begin
                op[hit_idx].dec_pin = 1'b1;
                op[hit_idx].set_dirty = req_q.mark_dirty;
                if (hpins == PIN_BITS'(1)) begin
                  lru_set[hit_idx] = 1'b1;
                  mv_en = 1'b1;
                end
              end
            end
          end
          CmdDelete: begin
            if (hit_f) begin
              rsp_d.frame = FrameW'(hit_idx);
              rsp_d.hit = 1'b1;
              op[hit_idx].free = 1'b1;
              lru_set[hit_idx] = 1'b1;
              mv_en = 1'b1;
            end
          end
          CmdFlush: begin
            if (hit_f) begin
              rsp_d.frame = FrameW'(hit_idx);
              rsp_d.hit = 1'b1;
              if (dirty[hit_idx]) begin
                op[hit_idx].clr_dirty = 1'b1;
                rsp_d.writeback_valid = 1'b1;
                rsp_d.writeback_page = req_q.page_id;
                rsp_d.writeback_frame = FrameW'(hit_idx);
              end
            end
          end
          CmdFlushAll: begin
            scan_d = '0;
            nres_d = '0;
            any_d = 1'b0;
            state_d = ST_SCAN;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        // One frame per cycle unless output is held; a dirty valid frame gives an item (up to MaxResults).
        if (valid[scan_q] && dirty[scan_q] && nres_q < 5'(MaxResults)) begin
          op[scan_q].clr_dirty = 1'b1;
          rsp_d = '0;
          rsp_d.frame = FrameW'(scan_q);
          rsp_d.hit = 1'b1;
          rsp_d.writeback_valid = 1'b1;
          rsp_d.writeback_page = pages[scan_q];
          rsp_d.writeback_frame = FrameW'(scan_q);
          rsp_d.last = 1'b1;
          for (int j = 0; j < NUM_FRAMES; j++) begin
            if (j > int'(scan_q) && valid[j] && dirty[j]) rsp_d.last = 1'b0;
          end
          if (nres_q == 5'(MaxResults - 1)) rsp_d.last = 1'b1;
          nres_d = nres_q + 5'd1;
          any_d = 1'b1;
          state_d = ST_OUT;
        end else if (scan_q == IdxW'(NUM_FRAMES - 1)) begin
          rsp_d = '0;
          rsp_d.last = 1'b1;
          state_d = any_q ? ST_IDLE : ST_OUT;
        end
        if (scan_q != IdxW'(NUM_FRAMES - 1)) scan_d = scan_q + 1'b1;
      end
      ST_OUT: begin
        if (rsp.ready) begin
          state_d = rsp_q.last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `BP_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, !req.ready,
    "request accepted while busy")
  `BP_ASSERT_NEXT(a_exec_after_accept, clk_i, rst_ni, req.valid && req.ready,
    state_q == ST_EXEC, "accepted item not executed")
  `BP_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp.valid && !rsp.ready,
    rsp.valid && $stable(rsp_q), "stalled result changed")

endmodule
